// File: hdl/nru_page_replacement_macros.svh
// Assertion macros shared by the page replacement block.
`ifndef NRU_PAGE_REPLACEMENT_MACROS_SVH
`define NRU_PAGE_REPLACEMENT_MACROS_SVH

// Same-cycle implication, ignored while reset is asserted.
`define NRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, ignored while reset is asserted.
`define NRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hdl/nru_pkg.sv
package nru_pkg;

  localparam int NUM_FRAMES = 4;
  localparam int PAGE_BITS  = 8;

  // Frame index and class member count widths.
  localparam int FW    = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int CNT_W = $clog2(NUM_FRAMES + 1);

  // Port widths fixed by the interface.
  localparam int IN_PAGE_W  = 8;
  localparam int OUT_IDX_W  = 2;
  localparam int OUT_PAGE_W = 8;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int FIU_W      = 3;

  // Remainder unit operand width and step counter width.
  localparam int DIV_W   = 16;
  localparam int DSTEP_W = $clog2(DIV_W + 1);

  localparam logic [DIV_W-1:0] LFSR_SEED      = 16'hACE1;
  localparam logic [DIV_W-1:0] PERIOD_RESET   = 16'd5;
  localparam logic [FIU_W-1:0] FIU_RESET      = 3'd3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RESET_PERIOD  = 1'b0,
    REG_FRAMES_IN_USE = 1'b1
  } nru_reg_t;

endpackage

// File: hdl/nru_rem.sv
`include "nru_page_replacement_macros.svh"

// Restoring remainder unit: one quotient bit per cycle.
module nru_rem (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [nru_pkg::DIV_W-1:0] dividend,
  input  logic [nru_pkg::DIV_W-1:0] divisor,
  output logic                      done,
  output logic [nru_pkg::DIV_W-1:0] remainder
);
  import nru_pkg::*;

  logic [DIV_W-1:0]   dvd_r, dvd_nxt;
  logic [DIV_W-1:0]   dvs_r, dvs_nxt;
  logic [DIV_W-1:0]   rem_r, rem_nxt;
  logic [DSTEP_W-1:0] cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [DIV_W:0]     trial;

  assign trial = {rem_r, dvd_r[DIV_W-1]};

  always_comb begin
    dvd_nxt  = dvd_r;
    dvs_nxt  = dvs_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      dvd_nxt  = dividend;
      dvs_nxt  = divisor;
      rem_nxt  = '0;
      cnt_nxt  = DSTEP_W'(DIV_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      dvd_nxt = {dvd_r[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DIV_W'(trial - {1'b0, dvs_r});
      end else begin
        rem_nxt = trial[DIV_W-1:0];
      end
      cnt_nxt = cnt_r - DSTEP_W'(1);
      if (cnt_r == DSTEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    dvd_r <= dvd_nxt;
    dvs_r <= dvs_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign remainder = rem_r;

  `NRU_ASSERT_IMPL(a_rem_below_divisor, clk, rst_n, done_r, rem_r < dvs_r, "remainder not below divisor")
  `NRU_ASSERT_IMPL(a_no_start_when_busy, clk, rst_n, start, !busy_r, "remainder unit restarted while busy")

endmodule

// File: hdl/nru_page_replacement.sv
// Channel | Handshake    | Fields
// request | start, busy  | in_page_number, in_is_write
// result  | out_valid    | out_hit, out_frame_index, out_evicted_valid/page, out_fault_total
// config  | cfg_we       | cfg_index, cfg_wdata
//
// A request is accepted at a rising edge with start high and busy low. The
// lookup comes first, then one pass of the 16-step remainder unit, or two when a
// frame is evicted, and then the out_valid strobe.
// One pass is for the reference-period check and one more for the victim position.
// Busy falls in the strobe cycle, so a new request can go in once the last has its result.
// Reset is synchronous and active low; the receiver cannot stall the result.
`include "nru_page_replacement_macros.svh"

module nru_page_replacement (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [nru_pkg::IN_PAGE_W-1:0] in_page_number,
  input  logic                          in_is_write,
  output logic                          out_valid,
  output logic                          out_hit,
  output logic [nru_pkg::OUT_IDX_W-1:0] out_frame_index,
  output logic                          out_evicted_valid,
  output logic [nru_pkg::OUT_PAGE_W-1:0] out_evicted_page,
  output logic [nru_pkg::DIV_W-1:0]     out_fault_total,
  input  logic                          cfg_we,
  input  logic [nru_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [nru_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import nru_pkg::*;

  // The sequencer walks a request through lookup, an optional victim choice
  // and the reference-period check, all sharing one remainder unit.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOOK = 4'b0010,
    S_VICT = 4'b0100,
    S_PDIV = 4'b1000
  } nru_state_t;

  nru_state_t state_r, state_nxt;

  // Configuration registers.
  logic [DIV_W-1:0] period_r, period_nxt;
  logic [FIU_W-1:0] fiu_r, fiu_nxt;

  // Frame table.
  logic [PAGE_BITS-1:0]  page_r [NUM_FRAMES];
  logic [PAGE_BITS-1:0]  page_nxt [NUM_FRAMES];
  logic [NUM_FRAMES-1:0] valid_r, valid_nxt;
  logic [NUM_FRAMES-1:0] refd_r, refd_nxt;
  logic [NUM_FRAMES-1:0] mod_r, mod_nxt;

  logic [DIV_W-1:0] ref_idx_r, ref_idx_nxt;
  logic [DIV_W-1:0] lfsr_r, lfsr_nxt;
  logic [DIV_W-1:0] fault_r, fault_nxt;

  // The request under way.
  logic [PAGE_BITS-1:0] req_page_r, req_page_nxt;
  logic                 req_wr_r, req_wr_nxt;
  logic [1:0]           cls_r, cls_nxt;

  // Result registers.
  logic                 out_valid_r, out_valid_nxt;
  logic                 hit_r, hit_nxt;
  logic [FW-1:0]        tgt_r, tgt_nxt;
  logic                 ev_valid_r, ev_valid_nxt;
  logic [PAGE_BITS-1:0] ev_page_r, ev_page_nxt;

  // Shared remainder unit.
  logic             div_start;
  logic [DIV_W-1:0] div_dividend, div_divisor;
  logic             div_done;
  logic [DIV_W-1:0] div_rem;

  // Lookup results.
  logic [CNT_W-1:0]      n_managed;
  logic [NUM_FRAMES-1:0] managed;
  logic                  look_hit, look_free;
  logic [FW-1:0]         hit_idx, free_idx;
  logic [CNT_W-1:0]      cls_cnt [4];
  logic [1:0]            low_cls;
  logic [CNT_W-1:0]      low_cnt;
  logic [FW-1:0]         victim;
  logic [CNT_W-1:0]      seen;
  logic                  vict_found;
  logic [DIV_W-1:0]      period_eff;
  logic                  lfsr_fb;

  nru_rem u_rem (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Zero frames in use counts as one; more than the built table is clipped.
  always_comb begin
    if (fiu_r == '0) begin
      n_managed = CNT_W'(1);
    end else if (32'(fiu_r) > NUM_FRAMES) begin
      n_managed = CNT_W'(NUM_FRAMES);
    end else begin
      n_managed = CNT_W'(fiu_r);
    end
    for (int f = 0; f < NUM_FRAMES; f++) begin
      managed[f] = (32'(f) < 32'(n_managed));
    end
  end

  assign period_eff = (period_r == '0) ? DIV_W'(1) : period_r;
  assign lfsr_fb    = lfsr_r[0] ^ lfsr_r[2] ^ lfsr_r[3] ^ lfsr_r[5];

  // Hit search, first free frame, the population of each NRU class and the lowest nonempty one.
  always_comb begin
    look_hit  = 1'b0;
    look_free = 1'b0;
    hit_idx   = '0;
    free_idx  = '0;
    for (int c = 0; c < 4; c++) begin
      cls_cnt[c] = '0;
    end
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if (managed[f] && valid_r[f] && (page_r[f] == req_page_r) && !look_hit) begin
        look_hit = 1'b1;
        hit_idx  = FW'(f);
      end
      if (managed[f] && !valid_r[f] && !look_free) begin
        look_free = 1'b1;
        free_idx  = FW'(f);
      end
      if (managed[f]) begin
        cls_cnt[{refd_r[f], mod_r[f]}] = cls_cnt[{refd_r[f], mod_r[f]}] + CNT_W'(1);
      end
    end
    low_cls = 2'd3;
    low_cnt = cls_cnt[3];
    for (int c = 2; c >= 0; c--) begin
      if (cls_cnt[c] != '0) begin
        low_cls = 2'(c);
        low_cnt = cls_cnt[c];
      end
    end
  end

  // The victim is the member of the chosen class whose rank equals the remainder.
  always_comb begin
    victim     = '0;
    seen       = '0;
    vict_found = 1'b0;
    for (int f = 0; f < NUM_FRAMES; f++) begin
      if (managed[f] && ({refd_r[f], mod_r[f]} == cls_r)) begin
        if ((DIV_W'(seen) == div_rem) && !vict_found) begin
          victim     = FW'(f);
          vict_found = 1'b1;
        end
        seen = seen + CNT_W'(1);
      end
    end
  end

  always_comb begin
    state_nxt     = state_r;
    period_nxt    = period_r;
    fiu_nxt       = fiu_r;
    page_nxt      = page_r;
    valid_nxt     = valid_r;
    refd_nxt      = refd_r;
    mod_nxt       = mod_r;
    ref_idx_nxt   = ref_idx_r;
    lfsr_nxt      = lfsr_r;
    fault_nxt     = fault_r;
    req_page_nxt  = req_page_r;
    req_wr_nxt    = req_wr_r;
    cls_nxt       = cls_r;
    out_valid_nxt = 1'b0;
    hit_nxt       = hit_r;
    tgt_nxt       = tgt_r;
    ev_valid_nxt  = ev_valid_r;
    ev_page_nxt   = ev_page_r;
    div_start     = 1'b0;
    div_dividend  = ref_idx_r;
    div_divisor   = period_eff;

    if (cfg_we) begin
      case (cfg_index)
        REG_RESET_PERIOD:  period_nxt = cfg_wdata;
        REG_FRAMES_IN_USE: fiu_nxt    = cfg_wdata[FIU_W-1:0];
        default: ;
      endcase
    end

    case (state_r)
      S_IDLE: begin
        if (start) begin
          req_page_nxt = in_page_number[PAGE_BITS-1:0];
          req_wr_nxt   = in_is_write;
          state_nxt    = S_LOOK;
        end
      end
      S_LOOK: begin
        hit_nxt      = look_hit;
        ev_valid_nxt = 1'b0;
        ev_page_nxt  = '0;
        if (look_hit) begin
          tgt_nxt           = hit_idx;
          refd_nxt[hit_idx] = 1'b1;
          if (req_wr_r) begin
            mod_nxt[hit_idx] = 1'b1;
          end
        end else begin
          if (fault_r != '1) begin
            fault_nxt = fault_r + DIV_W'(1);
          end
        end
        if (!look_hit && !look_free) begin
          // Every managed frame is taken: find the victim's rank first.
          cls_nxt      = low_cls;
          div_start    = 1'b1;
          div_dividend = lfsr_r;
          div_divisor  = DIV_W'(low_cnt);
          state_nxt    = S_VICT;
        end else begin
          if (!look_hit) begin
            tgt_nxt             = free_idx;
            page_nxt[free_idx]  = req_page_r;
            valid_nxt[free_idx] = 1'b1;
            refd_nxt[free_idx]  = 1'b1;
            mod_nxt[free_idx]   = req_wr_r;
          end
          div_start = 1'b1;
          state_nxt = S_PDIV;
        end
      end
      S_VICT: begin
        if (div_done) begin
          tgt_nxt          = victim;
          ev_valid_nxt     = 1'b1;
          ev_page_nxt      = page_r[victim];
          page_nxt[victim] = req_page_r;
          valid_nxt[victim] = 1'b1;
          refd_nxt[victim] = 1'b1;
          mod_nxt[victim]  = req_wr_r;
          lfsr_nxt         = {lfsr_fb, lfsr_r[DIV_W-1:1]};
          div_start        = 1'b1;
          state_nxt        = S_PDIV;
        end
      end
      S_PDIV: begin
        if (div_done) begin
          // The referenced bits of every frame clear on a period boundary.
          if (div_rem == '0) begin
            refd_nxt = '0;
          end
          ref_idx_nxt   = ref_idx_r + DIV_W'(1);
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      period_r    <= PERIOD_RESET;
      fiu_r       <= FIU_RESET;
      valid_r     <= '0;
      refd_r      <= '0;
      mod_r       <= '0;
      ref_idx_r   <= '0;
      lfsr_r      <= LFSR_SEED;
      fault_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      period_r    <= period_nxt;
      fiu_r       <= fiu_nxt;
      valid_r     <= valid_nxt;
      refd_r      <= refd_nxt;
      mod_r       <= mod_nxt;
      ref_idx_r   <= ref_idx_nxt;
      lfsr_r      <= lfsr_nxt;
      fault_r     <= fault_nxt;
      out_valid_r <= out_valid_nxt;
    end
    page_r     <= page_nxt;
    req_page_r <= req_page_nxt;
    req_wr_r   <= req_wr_nxt;
    cls_r      <= cls_nxt;
    hit_r      <= hit_nxt;
    tgt_r      <= tgt_nxt;
    ev_valid_r <= ev_valid_nxt;
    ev_page_r  <= ev_page_nxt;
  end

  assign busy              = (state_r != S_IDLE);
  assign out_valid         = out_valid_r;
  assign out_hit           = hit_r;
  assign out_frame_index   = OUT_IDX_W'(tgt_r);
  assign out_evicted_valid = ev_valid_r;
  assign out_evicted_page  = OUT_PAGE_W'(ev_page_r);
  assign out_fault_total   = fault_r;

  `NRU_ASSERT_NEXT(a_pdiv_done_strobes, clk, rst_n, (state_r == S_PDIV) && div_done, out_valid_r, "period check finished without a result strobe")
  `NRU_ASSERT_IMPL(a_evict_only_on_miss, clk, rst_n, out_valid_r && out_evicted_valid, !out_hit, "eviction reported on a hit")

endmodule

// File: tb/tb_nru_page_replacement.sv
module tb_nru_page_replacement;
  timeunit 1ns;
  timeprecision 1ps;

  import nru_pkg::*;

  // A run that sees no request and no result for this many cycles has hung.
  // The limit lies well above the slowest request and the longest sender gap.
  localparam int WATCHDOG_LIMIT = 2000;

  // Results past this count are still checked but no longer printed.
  localparam int REPORT_CAP = 200;

  // One result as the block presents it on the out_ ports.
  typedef struct packed {
    logic                  hit;
    logic [OUT_IDX_W-1:0]  frame;
    logic                  ev_valid;
    logic [OUT_PAGE_W-1:0] ev_page;
    logic [DIV_W-1:0]      faults;
  } page_result_t;

  // The scoreboard keeps its own copy of the frame table, the victim LFSR and
  // the two registers. Every accepted request is played through that copy at
  // once, and the result it should produce is queued until the block's strobe
  // brings the real one.
  class nru_scoreboard;
    page_result_t      awaited[$];
    logic [PAGE_BITS-1:0] held_page[NUM_FRAMES];
    bit                held_valid[NUM_FRAMES];
    bit                held_ref[NUM_FRAMES];
    bit                held_mod[NUM_FRAMES];
    logic [DIV_W-1:0]  ref_count;
    logic [DIV_W-1:0]  victim_lfsr;
    logic [DIV_W-1:0]  fault_count;
    logic [DIV_W-1:0]  clear_period;
    logic [FIU_W-1:0]  frames_cfg;
    int                failures;
    int                reported;
    int                requests;
    int                hits;
    int                evictions;

    function new();
      for (int f = 0; f < NUM_FRAMES; f++) begin
        held_page[f]  = '0;
        held_valid[f] = 1'b0;
        held_ref[f]   = 1'b0;
        held_mod[f]   = 1'b0;
      end
      ref_count    = '0;
      victim_lfsr  = LFSR_SEED;
      fault_count  = '0;
      clear_period = PERIOD_RESET;
      frames_cfg   = FIU_RESET;
      failures     = 0;
      reported     = 0;
      requests     = 0;
      hits         = 0;
      evictions    = 0;
    endfunction

    function void write_reg(nru_reg_t idx, logic [CFG_DATA_W-1:0] data);
      if (idx == REG_RESET_PERIOD) begin
        clear_period = data;
      end else begin
        frames_cfg = data[FIU_W-1:0];
      end
    endfunction

    function int pending();
      return awaited.size();
    endfunction

    function void report(string msg);
      if (reported < REPORT_CAP) $display("%s", msg);
      reported++;
    endfunction

    function void note_request(logic [PAGE_BITS-1:0] page, logic wr);
      int              n;
      int              tgt;
      int              cnt;
      int              pos;
      int              seen;
      bit              hit_now;
      bit              free_now;
      bit              chosen;
      logic [DIV_W-1:0] period;
      page_result_t    want;

      // Zero frames means one, and anything past the built table is clipped.
      n = (frames_cfg == 0) ? 1 : ((frames_cfg > NUM_FRAMES) ? NUM_FRAMES : int'(frames_cfg));
      hit_now = 1'b0;
      free_now = 1'b0;
      tgt = 0;
      want = '0;

      for (int f = 0; f < n; f++) begin
        if (!hit_now && held_valid[f] && held_page[f] == page) begin
          hit_now = 1'b1;
          tgt = f;
        end
      end

      if (hit_now) begin
        held_ref[tgt] = 1'b1;
        if (wr) held_mod[tgt] = 1'b1;
        hits++;
      end else begin
        for (int f = 0; f < n; f++) begin
          if (!free_now && !held_valid[f]) begin
            free_now = 1'b1;
            tgt = f;
          end
        end
        if (!free_now) begin
          // Lowest nonempty class wins; inside it the LFSR picks the member.
          chosen = 1'b0;
          for (int c = 0; c < 4 && !chosen; c++) begin
            cnt = 0;
            for (int f = 0; f < n; f++)
              if ({held_ref[f], held_mod[f]} == c) cnt++;
            if (cnt != 0) begin
              pos = int'(victim_lfsr) % cnt;
              seen = 0;
              for (int f = 0; f < n; f++) begin
                if (!chosen && {held_ref[f], held_mod[f]} == c) begin
                  if (seen == pos) begin
                    tgt = f;
                    chosen = 1'b1;
                  end
                  seen++;
                end
              end
            end
          end
          victim_lfsr = {victim_lfsr[0] ^ victim_lfsr[2] ^ victim_lfsr[3] ^ victim_lfsr[5],
                         victim_lfsr[DIV_W-1:1]};
          want.ev_valid = 1'b1;
          want.ev_page = held_page[tgt];
          evictions++;
        end
        held_page[tgt]  = page;
        held_valid[tgt] = 1'b1;
        held_ref[tgt]   = 1'b1;
        held_mod[tgt]   = wr;
        if (fault_count != '1) fault_count++;
      end

      // The periodic clearing reaches every frame, managed or not.
      period = (clear_period == 0) ? DIV_W'(1) : clear_period;
      if (ref_count % period == 0)
        for (int f = 0; f < NUM_FRAMES; f++) held_ref[f] = 1'b0;
      ref_count++;

      want.hit = hit_now;
      want.frame = tgt[OUT_IDX_W-1:0];
      want.faults = fault_count;
      awaited.insert(awaited.size(), want);
      requests++;
    endfunction

    function void compare_field(string name, logic [DIV_W-1:0] want, logic [DIV_W-1:0] got);
      if (got !== want) begin
        failures++;
        report($sformatf("%0t: out_%s expected %0h, got %0h", $time, name, want, got));
      end
    endfunction

    function void check_result(page_result_t got);
      page_result_t want;
      if (awaited.size() == 0) begin
        failures++;
        report($sformatf("%0t: result with no request outstanding, expected none, got %h",
                         $time, got));
        return;
      end
      want = awaited.pop_front();
      compare_field("hit", DIV_W'(want.hit), DIV_W'(got.hit));
      compare_field("frame_index", DIV_W'(want.frame), DIV_W'(got.frame));
      compare_field("evicted_valid", DIV_W'(want.ev_valid), DIV_W'(got.ev_valid));
      compare_field("evicted_page", DIV_W'(want.ev_page), DIV_W'(got.ev_page));
      compare_field("fault_total", want.faults, got.faults);
    endfunction
  endclass

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   start = 1'b0;
  logic                   busy;
  logic [IN_PAGE_W-1:0]   in_page_number = '0;
  logic                   in_is_write = 1'b0;
  logic                   out_valid;
  logic                   out_hit;
  logic [OUT_IDX_W-1:0]   out_frame_index;
  logic                   out_evicted_valid;
  logic [OUT_PAGE_W-1:0]  out_evicted_page;
  logic [DIV_W-1:0]       out_fault_total;
  logic                   cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = REG_RESET_PERIOD;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  nru_scoreboard          sb = new();
  logic [IN_PAGE_W-1:0]   page_pool[6];
  int                     quiet_cycles = 0;

  nru_page_replacement u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_page_number    (in_page_number),
    .in_is_write       (in_is_write),
    .out_valid         (out_valid),
    .out_hit           (out_hit),
    .out_frame_index   (out_frame_index),
    .out_evicted_valid (out_evicted_valid),
    .out_evicted_page  (out_evicted_page),
    .out_fault_total   (out_fault_total),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Results are taken at the rising edge that closes the strobe cycle. The
  // receiver has no way to refuse them, so every strobe is checked at once.
  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1)
      sb.check_result({out_hit, out_frame_index, out_evicted_valid, out_evicted_page,
                       out_fault_total});
  end

  // The watchdog is cleared by any accepted request or any result; anything
  // else counts as a quiet cycle.
  always @(posedge clk) begin
    if ((start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("tb_nru_page_replacement failed");
      $finish;
    end
  end

  // Presents one request after an optional gap and holds it until the block
  // takes it. Start is left high on return, so that a following request can
  // go out back to back; the next call or a drain decides whether it falls.
  // Most gaps are short, but now and then a long one lets the request arrive
  // after busy has dropped, so gaps land on every part of the block's work.
  task automatic send_request(input logic [IN_PAGE_W-1:0] page, input logic wr,
                              input int idle_pct);
    int gap;
    gap = 0;
    while (gap < 60 && $urandom_range(99) < idle_pct) gap++;
    if (idle_pct > 0 && $urandom_range(7) == 0) gap += $urandom_range(40);
    @(negedge clk);
    repeat (gap) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_page_number <= page;
    in_is_write <= wr;
    do @(posedge clk); while (busy !== 1'b0);
    sb.note_request(page, wr);
  endtask

  // Lowers start and waits until every outstanding request has produced its
  // result. Since each request yields exactly one result and busy falls in the
  // strobe cycle, the block is idle once this returns.
  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input nru_reg_t idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random phase under a fixed register setting. Most requests come from a
  // small pool of pages, so that hits, refills and every eviction class turn up
  // often; the rest are arbitrary pages. Two pool entries are replaced at the
  // start of each phase, so pages left in frames that a smaller setting stopped
  // managing can be hit again once a larger setting brings those frames back.
  task automatic run_phase(input logic [CFG_DATA_W-1:0] period, input logic [FIU_W-1:0] fiu,
                           input int idle_pct, input int count, input bit hold_off);
    logic [IN_PAGE_W-1:0] page;
    drain();
    write_reg(REG_RESET_PERIOD, period);
    write_reg(REG_FRAMES_IN_USE, CFG_DATA_W'(fiu));
    repeat (2) page_pool[$urandom_range(5)] = IN_PAGE_W'($urandom);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 85) begin
        page = page_pool[$urandom_range(5)];
      end else begin
        page = IN_PAGE_W'($urandom);
      end
      send_request(page, 1'($urandom_range(1)), idle_pct);
      // Now and then the sender holds off until the block has answered
      // everything it has taken.
      if (hold_off && i % 37 == 36) drain();
    end
  endtask

  initial begin
    page_pool = '{8'h00, 8'hFF, 8'h5A, 8'hA5, 8'h3C, 8'hC3};
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // Directed part under the reset setting of three frames and a period of
    // five. Page zero comes first: it matches the scoreboard's zeroed frame copy but
    // must still miss, as no frame is valid yet. The table then fills, takes
    // read and write hits, and is forced into evictions.
    send_request(8'h00, 1'b0, 0);
    send_request(8'hFF, 1'b1, 0);
    send_request(8'h5A, 1'b0, 0);
    send_request(8'hFF, 1'b0, 0);
    send_request(8'h00, 1'b1, 0);
    send_request(8'hA5, 1'b1, 0);
    send_request(8'h5A, 1'b0, 0);
    send_request(8'h3C, 1'b0, 0);
    send_request(8'h00, 1'b0, 0);
    send_request(8'hC3, 1'b1, 0);

    // A frame count above the built table is clipped to four, and a zero
    // period behaves as a clearing after every request.
    drain();
    write_reg(REG_FRAMES_IN_USE, 16'd7);
    write_reg(REG_RESET_PERIOD, 16'd0);
    send_request(8'h11, 1'b1, 0);
    send_request(8'h22, 1'b0, 0);
    send_request(8'hFF, 1'b1, 0);
    send_request(8'h33, 1'b0, 0);

    // A zero frame count manages frame zero alone; the other frames keep
    // their pages untouched.
    drain();
    write_reg(REG_FRAMES_IN_USE, 16'd0);
    send_request(8'h44, 1'b1, 0);
    send_request(8'h44, 1'b0, 0);
    send_request(8'h55, 1'b0, 0);

    // Back to the full table with the longest period, so that the pages kept
    // in the unmanaged frames can be found again.
    drain();
    write_reg(REG_FRAMES_IN_USE, 16'd4);
    write_reg(REG_RESET_PERIOD, 16'hFFFF);
    send_request(8'h22, 1'b0, 0);
    send_request(8'hFF, 1'b0, 0);
    send_request(8'h80, 1'b1, 0);
    send_request(8'h7F, 1'b0, 0);
    send_request(8'h01, 1'b1, 0);

    // Random phases. The receiver cannot hold results off, so the phases meant
    // for a stalling receiver run with a sender that never idles, and the
    // phases meant for both sides idling use the sender's share alone.
    run_phase(16'd3,     3'd4, 0,  140, 1'b0);
    run_phase(16'hFFFF,  3'd4, 79, 120, 1'b0);
    run_phase(16'd1,     3'd2, 0,  100, 1'b0);
    run_phase(16'd7,     3'd3, 33, 120, 1'b0);
    run_phase(16'd2,     3'd5, 0,  100, 1'b0);
    run_phase(16'd0,     3'd1, 79, 60,  1'b0);
    run_phase(16'd4,     3'd4, 33, 120, 1'b1);
    run_phase(16'd10,    3'd6, 0,  70,  1'b0);

    // Let the last results arrive, then watch a little longer than the
    // slowest request for any strobe that nothing asked for.
    drain();
    repeat (40) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.failures += sb.pending();
      $display("%0t: %0d results never arrived", $time, sb.pending());
    end
    if (sb.reported > REPORT_CAP)
      $display("%0d further mismatch lines were not printed", sb.reported - REPORT_CAP);

    $display("Checked %0d page references: %0d hits, %0d evictions, %0d faults counted,",
             sb.requests, sb.hits, sb.evictions, sb.fault_count);
    $display("over eleven register settings including zero and oversized frame counts.");
    if (sb.failures == 0) begin
      $display("tb_nru_page_replacement passed");
    end else begin
      $display("tb_nru_page_replacement failed");
    end
    $finish;
  end

endmodule
